### sv/gridded_bin_averager_macros.svh
// Assertion helpers shared by the RTL
`ifndef GRIDDED_BIN_AVERAGER_MACROS_SVH
`define GRIDDED_BIN_AVERAGER_MACROS_SVH

// same-cycle implication, checked out of reset
`define GBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gba_pkg.sv
package gba_pkg;

    localparam int MAX_HOURS     = 4;
    localparam int MAX_LAT_CELLS = 256;
    localparam int MAX_LON_CELLS = 256;
    localparam int HOUR_W        = 2;
    localparam int LAT_W         = 8;
    localparam int LON_W         = 8;
    localparam int CELL_AW       = HOUR_W + LAT_W + LON_W;

    localparam int DIV_DW        = 48;
    localparam int DIV_SW        = 24;
    localparam int DIV_NW        = 6;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OUTSIDE = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_SAT     = 3'd3;
    localparam logic [2:0] ST_BADIDX  = 3'd4;

    localparam logic [2:0] REG_LAT_ORIGIN = 3'd0;
    localparam logic [2:0] REG_LON_ORIGIN = 3'd1;
    localparam logic [2:0] REG_CELL_SIZE  = 3'd2;
    localparam logic [2:0] REG_LAT_USED   = 3'd3;
    localparam logic [2:0] REG_LON_USED   = 3'd4;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] nbits;
    } div_ctl_t;

endpackage

### sv/gba_div.sv
module gba_div
    import gba_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctl_t          ctl,
    input  logic [DIV_DW-1:0] dividend,
    input  logic [DIV_SW-1:0] divisor,
    output logic              done,
    output logic [DIV_DW-1:0] quotient
);

    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_SW-1:0] rem_reg;
    logic [DIV_SW-1:0] dsr_reg;
    logic [DIV_NW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_SW:0]   cand;
    logic              ge;

    // dividend arrives left-aligned; low nbits of quo_reg hold the quotient
    assign cand = {rem_reg, quo_reg[DIV_DW-1]};
    assign ge   = cand >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.nbits;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_NW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_DW-2:0], ge};
            rem_reg <= ge ? DIV_SW'(cand - {1'b0, dsr_reg}) : cand[DIV_SW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/gridded_bin_averager.sv
// An add point runs up to two 25-step divides (latitude bin, then longitude bin),
// a read one 48-step divide for the average; an empty-cell read, an outside-grid
// point, a bad index, a full hour table and an ignored opcode skip or cut them short.
// Clear zeroes the whole memory, one grid cell per cycle.
// One item at a time; the shared bit-serial divider and output back-pressure set the rate.
// Reset (aresetn low, synchronous) restores the control registers and runs the same
// memory clearing pass before the first beat is accepted.
`include "gridded_bin_averager_macros.svh"

module gridded_bin_averager
    import gba_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [24:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, hour_key, latitude, longitude, sample_value, read_hour, read_lat, read_lon
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, hour_index, lat_bin, lon_bin, cell_average, cell_count
    output logic [71:0]  m_tdata
);

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_HOUR = 9'b000000100,
        S_LATD = 9'b000001000,
        S_LOND = 9'b000010000,
        S_MRD  = 9'b000100000,
        S_MUPD = 9'b001000000,
        S_AVG  = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [24:0] lat_origin_reg;
    logic signed [24:0] lon_origin_reg;
    logic [23:0]        cell_size_reg;
    logic [8:0]         lat_used_reg;
    logic [8:0]         lon_used_reg;

    logic [CELL_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic               clr_fin_reg, clr_fin_next;
    logic [2:0]         hours_reg, hours_next;
    logic [31:0]        keys_reg [MAX_HOURS];
    logic               key_we;

    logic [1:0]         op_reg, op_next;
    logic [31:0]        key_reg, key_next;
    logic signed [24:0] lat_reg, lat_next;
    logic signed [24:0] lon_reg, lon_next;
    logic signed [31:0] val_reg, val_next;
    logic [1:0]         rh_reg, rh_next;
    logic [7:0]         rl_reg, rl_next;
    logic [7:0]         ro_reg, ro_next;

    logic [2:0]         status_reg, status_next;
    logic [1:0]         hidx_reg, hidx_next;
    logic [7:0]         lb_reg, lb_next;
    logic [7:0]         ob_reg, ob_next;
    logic [31:0]        avg_reg, avg_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic [CELL_AW-1:0] addr_reg, addr_next;
    logic               neg_reg, neg_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [71:0]        m_tdata_reg, m_tdata_next;

    logic [63:0]        mem [2**CELL_AW];
    logic [63:0]        mem_q;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_addr;
    logic [63:0]        mem_wdata;

    div_ctl_t           div_ctl;
    logic [DIV_DW-1:0]  div_dividend;
    logic [DIV_SW-1:0]  div_divisor;
    logic               div_done;
    logic [DIV_DW-1:0]  div_quo;

    logic signed [25:0] dlat, dlon;
    logic [8:0]         lat_lim, lon_lim;
    logic               hit;
    logic [1:0]         hit_idx;
    logic [47:0]        mem_sum;
    logic [15:0]        mem_cnt;
    logic               s_acc;

    assign s_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign dlat    = {lat_reg[24], lat_reg} - {lat_origin_reg[24], lat_origin_reg};
    assign dlon    = {lon_reg[24], lon_reg} - {lon_origin_reg[24], lon_origin_reg};
    assign lat_lim = (lat_used_reg > 9'(MAX_LAT_CELLS)) ? 9'(MAX_LAT_CELLS) : lat_used_reg;
    assign lon_lim = (lon_used_reg > 9'(MAX_LON_CELLS)) ? 9'(MAX_LON_CELLS) : lon_used_reg;
    assign mem_sum = mem_q[63:16];
    assign mem_cnt = mem_q[15:0];

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < MAX_HOURS; i++) begin
            if (!hit && (3'(i) < hours_reg) && (keys_reg[i] == key_reg)) begin
                hit     = 1'b1;
                hit_idx = 2'(i);
            end
        end
    end

    gba_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_fin_next  = clr_fin_reg;
        hours_next    = hours_reg;
        key_we        = 1'b0;
        op_next       = op_reg;
        key_next      = key_reg;
        lat_next      = lat_reg;
        lon_next      = lon_reg;
        val_next      = val_reg;
        rh_next       = rh_reg;
        rl_next       = rl_reg;
        ro_next       = ro_reg;
        status_next   = status_reg;
        hidx_next     = hidx_reg;
        lb_next       = lb_reg;
        ob_next       = ob_reg;
        avg_next      = avg_reg;
        cnt_next      = cnt_reg;
        addr_next     = addr_reg;
        neg_next      = neg_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_addr      = addr_reg;
        mem_wdata     = '0;
        div_ctl       = '0;
        div_dividend  = '0;
        div_divisor   = cell_size_reg;

        case (state_reg)
            S_INIT: begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    clr_fin_next = 1'b0;
                    state_next   = clr_fin_reg ? S_FIN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    op_next     = s_tdata[1:0];
                    key_next    = s_tdata[33:2];
                    lat_next    = s_tdata[58:34];
                    lon_next    = s_tdata[83:59];
                    val_next    = s_tdata[115:84];
                    rh_next     = s_tdata[117:116];
                    rl_next     = s_tdata[125:118];
                    ro_next     = s_tdata[133:126];
                    status_next = ST_OK;
                    hidx_next   = '0;
                    lb_next     = '0;
                    ob_next     = '0;
                    avg_next    = '0;
                    cnt_next    = '0;
                    state_next  = S_HOUR;
                end
            end
            S_HOUR: begin
                case (op_reg)
                    OP_ADD: begin
                        if (!hit && hours_reg >= 3'(MAX_HOURS)) begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end else begin
                            if (hit) begin
                                hidx_next = hit_idx;
                            end else begin
                                hidx_next  = hours_reg[1:0];
                                key_we     = 1'b1;
                                hours_next = hours_reg + 1'b1;
                            end
                            if (dlat[25] || dlon[25] || cell_size_reg == '0) begin
                                status_next = ST_OUTSIDE;
                                state_next  = S_FIN;
                            end else begin
                                div_ctl.start = 1'b1;
                                div_ctl.nbits = DIV_NW'(25);
                                div_dividend  = {dlat[24:0], 23'd0};
                                state_next    = S_LATD;
                            end
                        end
                    end
                    OP_READ: begin
                        hidx_next = rh_reg;
                        lb_next   = rl_reg;
                        ob_next   = ro_reg;
                        if ({1'b0, rh_reg} >= hours_reg || {1'b0, rl_reg} >= lat_lim ||
                            {1'b0, ro_reg} >= lon_lim) begin
                            status_next = ST_BADIDX;
                            state_next  = S_FIN;
                        end else begin
                            addr_next  = {rh_reg, rl_reg, ro_reg};
                            state_next = S_MRD;
                        end
                    end
                    OP_CLEAR: begin
                        hours_next   = '0;
                        clr_cnt_next = '0;
                        clr_fin_next = 1'b1;
                        state_next   = S_INIT;
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_LATD: begin
                if (div_done) begin
                    if (div_quo[24:0] >= 25'(lat_lim)) begin
                        status_next = ST_OUTSIDE;
                        state_next  = S_FIN;
                    end else begin
                        lb_next       = div_quo[7:0];
                        div_ctl.start = 1'b1;
                        div_ctl.nbits = DIV_NW'(25);
                        div_dividend  = {dlon[24:0], 23'd0};
                        state_next    = S_LOND;
                    end
                end
            end
            S_LOND: begin
                if (div_done) begin
                    if (div_quo[24:0] >= 25'(lon_lim)) begin
                        status_next = ST_OUTSIDE;
                        lb_next     = '0;
                        state_next  = S_FIN;
                    end else begin
                        ob_next    = div_quo[7:0];
                        addr_next  = {hidx_reg, lb_reg, div_quo[7:0]};
                        state_next = S_MRD;
                    end
                end
            end
            S_MRD: begin
                state_next = S_MUPD;
            end
            S_MUPD: begin
                if (op_reg == OP_ADD) begin
                    if (&mem_cnt) begin
                        status_next = ST_SAT;
                        cnt_next    = mem_cnt;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {mem_sum + {{16{val_reg[31]}}, val_reg}, mem_cnt + 1'b1};
                        cnt_next  = mem_cnt + 1'b1;
                    end
                    state_next = S_FIN;
                end else begin
                    cnt_next = mem_cnt;
                    if (mem_cnt == '0) begin
                        state_next = S_FIN;
                    end else begin
                        neg_next      = mem_sum[47];
                        div_ctl.start = 1'b1;
                        div_ctl.nbits = DIV_NW'(DIV_DW);
                        div_dividend  = mem_sum[47] ? (48'd0 - mem_sum) : mem_sum;
                        div_divisor   = {8'd0, mem_cnt};
                        state_next    = S_AVG;
                    end
                end
            end
            S_AVG: begin
                div_divisor = {8'd0, cnt_reg};
                if (div_done) begin
                    avg_next   = neg_reg ? (32'd0 - div_quo[31:0]) : div_quo[31:0];
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, cnt_reg, avg_reg, ob_reg, lb_reg, hidx_reg,
                                     status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            keys_reg[hours_reg[1:0]] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            clr_cnt_reg    <= '0;
            clr_fin_reg    <= 1'b0;
            hours_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            lat_origin_reg <= 25'sd327680;
            lon_origin_reg <= 25'sd4259840;
            cell_size_reg  <= 24'd16384;
            lat_used_reg   <= 9'd140;
            lon_used_reg   <= 9'd140;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_fin_reg  <= clr_fin_next;
            hours_reg    <= hours_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LAT_ORIGIN: lat_origin_reg <= cfg_wdata;
                    REG_LON_ORIGIN: lon_origin_reg <= cfg_wdata;
                    REG_CELL_SIZE:  cell_size_reg  <= cfg_wdata[23:0];
                    REG_LAT_USED:   lat_used_reg   <= cfg_wdata[8:0];
                    REG_LON_USED:   lon_used_reg   <= cfg_wdata[8:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        lat_reg     <= lat_next;
        lon_reg     <= lon_next;
        val_reg     <= val_next;
        rh_reg      <= rh_next;
        rl_reg      <= rl_next;
        ro_reg      <= ro_next;
        status_reg  <= status_next;
        hidx_reg    <= hidx_next;
        lb_reg      <= lb_next;
        ob_reg      <= ob_next;
        avg_reg     <= avg_next;
        cnt_reg     <= cnt_next;
        addr_reg    <= addr_next;
        neg_reg     <= neg_next;
        m_tdata_reg <= m_tdata_next;
    end

    `GBA_ASSERT_IMP(a_hours_bound, 1'b1, hours_reg <= 3'(MAX_HOURS), "hour count overflow")
    `GBA_ASSERT_IMP(a_div_owner, div_done, state_reg == S_LATD || state_reg == S_LOND || state_reg == S_AVG, "divider done outside a divide step")
    `GBA_ASSERT_NXT(a_clear_sweep, state_reg == S_HOUR && op_reg == OP_CLEAR, state_reg == S_INIT && hours_reg == '0, "clear did not start sweep")
    `GBA_ASSERT_IMP(a_out_source, $rose(m_tvalid_reg), $past(state_reg) == S_FIN, "result raised outside finish step")

endmodule
